[hdl/ab_blit_pkg.sv]
// ============================================================================
// ab_blit_pkg
// Shared types, constants and arithmetic for the alpha-blend bitmap blit.
// ============================================================================
package ab_blit_pkg;

    // width of the source row and column counters
    localparam int COORD_BITS = 16;

    // header register widths
    localparam int DIM_BITS   = 16;
    localparam int SIZE_BITS  = DIM_BITS + 1;
    localparam int COLOR_BITS = 24;
    localparam int PIXEL_BITS = 32;
    localparam int ADDR_BITS  = 32;
    localparam int DATA_BITS  = 32;
    localparam int INDEX_BITS = 3;

    localparam logic [SIZE_BITS-1:0] COORD_LIMIT = SIZE_BITS'(1) << COORD_BITS;

    localparam logic [31:0] RB_MASK = 32'h00FF_00FF;
    localparam logic [31:0] G_MASK  = 32'h0000_FF00;

    localparam logic [DIM_BITS-1:0] BPP_DRAWN        = 16'd32;
    localparam logic [31:0]         COMP_NONE        = 32'd0;
    localparam logic [31:0]         COMP_BITFIELDS   = 32'd3;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_DEST_X           = 3'd0,
        REG_DEST_Y           = 3'd1,
        REG_FRAME_WIDTH      = 3'd2,
        REG_IMAGE_WIDTH      = 3'd3,
        REG_IMAGE_HEIGHT     = 3'd4,
        REG_BACKGROUND_COLOR = 3'd5,
        REG_BITS_PER_PIXEL   = 3'd6,
        REG_COMPRESSION_KIND = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]   dest_x;
        logic [DIM_BITS-1:0]   dest_y;
        logic [DIM_BITS-1:0]   frame_width;
        logic [DIM_BITS-1:0]   image_width;
        logic [DIM_BITS-1:0]   image_height;
        logic [COLOR_BITS-1:0] background_color;
        logic [DIM_BITS-1:0]   bits_per_pixel;
        logic [31:0]           compression_kind;
    } cfg_t;

    // one pixel after the scan stage, on its way to the blend stage
    typedef struct packed {
        logic                  valid;
        logic [PIXEL_BITS-1:0] pixel;
        logic [ADDR_BITS-1:0]  row;
        logic [SIZE_BITS-1:0]  col;
        logic                  last;
    } scan_beat_t;

    // zero counts as one, sizes beyond the counters are clamped
    function automatic logic [SIZE_BITS-1:0] eff_size(input logic [DIM_BITS-1:0] v);
        logic [SIZE_BITS-1:0] wide;
        wide = SIZE_BITS'(v);
        if (v == '0) begin
            return SIZE_BITS'(1);
        end else if (wide > COORD_LIMIT) begin
            return COORD_LIMIT;
        end
        return wide;
    endfunction

    function automatic logic format_ok(input cfg_t c);
        return (c.bits_per_pixel == BPP_DRAWN) &&
               ((c.compression_kind == COMP_NONE) ||
                (c.compression_kind == COMP_BITFIELDS));
    endfunction

    // two-lane blend, all lane math wraps at 32 bits
    function automatic logic [COLOR_BITS-1:0] blend_px(
        input logic [COLOR_BITS-1:0] bg,
        input logic [PIXEL_BITS-1:0] fg
    );
        logic [31:0] alpha;
        logic [31:0] rb;
        logic [31:0] g;
        logic [31:0] rb_prod;
        logic [31:0] g_prod;
        logic [31:0] mixed;
        alpha   = {24'h0, fg[31:24]};
        rb      = {8'h0, bg} & RB_MASK;
        g       = {8'h0, bg} & G_MASK;
        rb_prod = ((fg & RB_MASK) - rb) * alpha;
        g_prod  = ((fg & G_MASK) - g) * alpha;
        rb      = rb + (rb_prod >> 8);
        g       = g + (g_prod >> 8);
        mixed   = (rb & RB_MASK) | (g & G_MASK);
        return mixed[COLOR_BITS-1:0];
    endfunction

endpackage

[hdl/ab_blit_cfg.sv]
// ============================================================================
// ab_blit_cfg
// Configuration register file, written one register per enabled cycle.
// ============================================================================
module ab_blit_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ab_blit_pkg::INDEX_BITS-1:0]  cfg_index,
    input  logic [ab_blit_pkg::DATA_BITS-1:0]   cfg_wdata,
    output ab_blit_pkg::cfg_t                   cfg
);
    import ab_blit_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_DEST_X:           cfg_next.dest_x           = cfg_wdata[DIM_BITS-1:0];
                REG_DEST_Y:           cfg_next.dest_y           = cfg_wdata[DIM_BITS-1:0];
                REG_FRAME_WIDTH:      cfg_next.frame_width      = cfg_wdata[DIM_BITS-1:0];
                REG_IMAGE_WIDTH:      cfg_next.image_width      = cfg_wdata[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT:     cfg_next.image_height     = cfg_wdata[DIM_BITS-1:0];
                REG_BACKGROUND_COLOR: cfg_next.background_color = cfg_wdata[COLOR_BITS-1:0];
                REG_BITS_PER_PIXEL:   cfg_next.bits_per_pixel   = cfg_wdata[DIM_BITS-1:0];
                REG_COMPRESSION_KIND: cfg_next.compression_kind = cfg_wdata[31:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_x           <= '0;
            cfg_reg.dest_y           <= '0;
            cfg_reg.frame_width      <= DIM_BITS'(1);
            cfg_reg.image_width      <= DIM_BITS'(1);
            cfg_reg.image_height     <= DIM_BITS'(1);
            cfg_reg.background_color <= '0;
            cfg_reg.bits_per_pixel   <= BPP_DRAWN;
            cfg_reg.compression_kind <= COMP_NONE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/ab_blit_scan.sv]
// ============================================================================
// ab_blit_scan
// Input register with the row and column scan counters.
// ============================================================================
module ab_blit_scan (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ab_blit_pkg::cfg_t                   cfg,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ab_blit_pkg::PIXEL_BITS-1:0]  s_source_pixel,
    input  logic                                advance,
    output ab_blit_pkg::scan_beat_t             beat
);
    import ab_blit_pkg::*;

    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] row_next;
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] col_next;
    scan_beat_t            beat_reg;
    scan_beat_t            beat_next;

    logic                  take;
    logic [SIZE_BITS-1:0]  width_eff;
    logic [SIZE_BITS-1:0]  height_eff;
    logic [COORD_BITS:0]   row_p1;
    logic [COORD_BITS:0]   col_p1;
    logic                  end_row;
    logic                  last;

    assign s_ready = !beat_reg.valid || advance;
    assign take    = s_valid && s_ready && format_ok(cfg);

    assign width_eff  = eff_size(cfg.image_width);
    assign height_eff = eff_size(cfg.image_height);
    assign row_p1     = {1'b0, row_reg} + (COORD_BITS + 1)'(1);
    assign col_p1     = {1'b0, col_reg} + (COORD_BITS + 1)'(1);
    assign end_row    = SIZE_BITS'(col_p1) >= width_eff;
    assign last       = end_row && (SIZE_BITS'(row_p1) >= height_eff);

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (take) begin
            if (last) begin
                row_next = '0;
                col_next = '0;
            end else if (end_row) begin
                row_next = row_p1[COORD_BITS-1:0];
                col_next = '0;
            end else begin
                col_next = col_p1[COORD_BITS-1:0];
            end
        end
    end

    always_comb begin
        beat_next = beat_reg;
        if (s_ready) begin
            beat_next.valid = take;
            if (take) begin
                beat_next.pixel = s_source_pixel;
                // bottom-up rows land top-down in the frame
                beat_next.row   = ADDR_BITS'(cfg.dest_y) +
                                  ADDR_BITS'(height_eff - SIZE_BITS'(1)) -
                                  ADDR_BITS'(row_reg);
                beat_next.col   = SIZE_BITS'(cfg.dest_x) + SIZE_BITS'(col_reg);
                beat_next.last  = last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg        <= '0;
            col_reg        <= '0;
            beat_reg.valid <= 1'b0;
        end else begin
            row_reg        <= row_next;
            col_reg        <= col_next;
            beat_reg.valid <= beat_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg.pixel <= beat_next.pixel;
        beat_reg.row   <= beat_next.row;
        beat_reg.col   <= beat_next.col;
        beat_reg.last  <= beat_next.last;
    end

    assign beat = beat_reg;

endmodule

[hdl/ab_blit_blend.sv]
// ============================================================================
// ab_blit_blend
// Blend and frame address logic feeding the result register.
// ============================================================================
module ab_blit_blend (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ab_blit_pkg::cfg_t                   cfg,
    input  ab_blit_pkg::scan_beat_t             beat,
    output logic                                advance,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ab_blit_pkg::ADDR_BITS-1:0]   m_frame_address,
    output logic [ab_blit_pkg::COLOR_BITS-1:0]  m_blended_pixel,
    output logic                                m_last_pixel
);
    import ab_blit_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [ADDR_BITS-1:0]  addr_next;
    logic [COLOR_BITS-1:0] color_reg;
    logic [COLOR_BITS-1:0] color_next;
    logic                  last_reg;
    logic                  last_next;
    logic [ADDR_BITS-1:0]  row_base;

    assign advance  = !valid_reg || m_ready;
    assign row_base = beat.row * ADDR_BITS'(cfg.frame_width);

    always_comb begin
        valid_next = valid_reg;
        addr_next  = addr_reg;
        color_next = color_reg;
        last_next  = last_reg;
        if (advance) begin
            valid_next = beat.valid;
            addr_next  = row_base + ADDR_BITS'(beat.col);
            color_next = blend_px(cfg.background_color, beat.pixel);
            last_next  = beat.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg  <= addr_next;
        color_reg <= color_next;
        last_reg  <= last_next;
    end

    assign m_valid         = valid_reg;
    assign m_frame_address = addr_reg;
    assign m_blended_pixel = color_reg;
    assign m_last_pixel    = last_reg;

endmodule

[hdl/alpha_blend_bitmap_blit_core.sv]
// ============================================================================
// alpha_blend_bitmap_blit_core
// Blends a stream of ARGB source pixels over a background color and tags
// each with its frame-buffer word address.
// ============================================================================
// usage notes
// - source beats arrive on s_valid/s_ready/s_source_pixel in stored order:
//   bottom-up rows, left to right within a row
// - each drawn pixel leaves on m_valid/m_ready with its frame word address,
//   the blended 24-bit RGB color and a flag on the image's final pixel
// - registers are written through cfg_wr_en/cfg_index/cfg_wdata, one per
//   cycle, while the stream is idle
// - when the header format is not 32 bpp with compression 0 or 3, source
//   beats are taken and dropped, and the scan counters hold
// - an accepted beat passes through the input register and then the result
//   register before it shows on m_valid
// - throughput: one beat per cycle unless m_ready stalls, set by the single
//   pass from the scan register through the blend and address multipliers
// - a stall on m_ready holds the result register; the scan register keeps
//   one more beat, so s_ready drops only when both are full
// - reset clears the counters, the valid flags and the registers to their
//   defaults (sizes of one, 32 bpp, no compression)
// ============================================================================
module alpha_blend_bitmap_blit_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [ab_blit_pkg::INDEX_BITS-1:0]  cfg_index,
    input  logic [ab_blit_pkg::DATA_BITS-1:0]   cfg_wdata,
    // source pixels
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ab_blit_pkg::PIXEL_BITS-1:0]  s_source_pixel,
    // blended results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ab_blit_pkg::ADDR_BITS-1:0]   m_frame_address,
    output logic [ab_blit_pkg::COLOR_BITS-1:0]  m_blended_pixel,
    output logic                                m_last_pixel
);
    import ab_blit_pkg::*;

    cfg_t       cfg;
    scan_beat_t beat;
    logic       advance;

    // register file, to be kept static by the user while a stream is in flight; the block does not enforce it
    ab_blit_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // scan counters and input register: row/column offsets are formed here
    ab_blit_scan u_scan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_source_pixel (s_source_pixel),
        .advance        (advance),
        .beat           (beat)
    );

    // blend lanes and address multiply into the result register
    ab_blit_blend u_blend (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .beat            (beat),
        .advance         (advance),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_address (m_frame_address),
        .m_blended_pixel (m_blended_pixel),
        .m_last_pixel    (m_last_pixel)
    );

endmodule
